/* src/btffa_pkg.sv */
`default_nettype none
package btffa_pkg;

	// Request kinds.
	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	// Result status codes.
	localparam logic [1:0] ST_DONE = 2'd0;
	localparam logic [1:0] ST_NULL = 2'd1;
	localparam logic [1:0] ST_OOM  = 2'd2;

	// Tag layout and block geometry.
	localparam int unsigned WORD_BYTES  = 4;
	localparam logic [31:0] ALLOC_BIT   = 32'h1;
	localparam int unsigned MIN_BLOCK   = 16;
	localparam int unsigned FIRST_CHUNK = 4096;
	localparam int unsigned CHUNK_RESET = 4096;

	// Register map.
	localparam logic REG_GROW_CHUNK = 1'b0;

endpackage
`default_nettype wire

/* src/boundary_tag_first_fit_allocator_top.sv */
`default_nettype none
// Boundary-tag heap allocator. A request (op, request_bytes, block_offset) is taken when start
// is high and busy is low; exactly one word comes back on payload_offset and status, marked by
// done for a single cycle, and it must be captured then. Every request but a zero-size allocate
// goes through one shared tag memory with one read and one write per cycle, so its time is set
// by that port: an allocate walks the block headers in a first-fit search, then may grow the
// heap and merge, and then may split the block it chose; a free walks the headers up to the
// block, then tags it and merges. A zero-size allocate is answered in the cycle after it is
// taken and leaves busy low. After reset the block is busy while it lays down the prologue,
// the epilogue and, when the heap is large enough, the first free chunk; configuration writes
// are taken throughout.
module boundary_tag_first_fit_allocator_top #(
	parameter int HEAP_BYTES = 65536
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic        op,
	input  wire logic [15:0] request_bytes,
	input  wire logic [15:0] block_offset,
	output logic             done,
	output logic      [15:0] payload_offset,
	output logic      [1:0]  status,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready
);

	localparam int NWORDS = HEAP_BYTES / btffa_pkg::WORD_BYTES;
	localparam int IW     = $clog2(NWORDS);
	localparam int OW     = $clog2(HEAP_BYTES + 1);
	localparam int W      = ((OW > 18) ? OW : 18) + 1;
	localparam bit FIT    = (HEAP_BYTES >= 16 + btffa_pkg::FIRST_CHUNK);
	localparam logic [W-1:0] HEAP_W = W'(HEAP_BYTES);
	localparam logic [W-1:0] MINB_W = W'(btffa_pkg::MIN_BLOCK);
	localparam logic [W-1:0] CH_W   = W'(btffa_pkg::FIRST_CHUNK);
	localparam logic [2:0]   INI_LAST = FIT ? 3'd5 : 3'd3;

	typedef enum logic [4:0] {
		S_INIT, S_IDLE, S_FF_RD, S_FF_CHK, S_GROW, S_GW0, S_GW1, S_GW2,
		S_M_H, S_M_P, S_M_N, S_M_C, S_MW0, S_MW1, S_C0, S_C1, S_C2, S_C3,
		S_L_RD, S_L_CHK, S_F0, S_F1
	} state_t;

	state_t          state_q;
	logic [2:0]      ini_q;
	logic            op_q;
	logic [W-1:0]    brk_q, bp_q, need_q, csz_q, mbp_q, msz_q, prev_q, tgt_q;
	logic            prev_al_q;
	logic [16:0]     chunk_q;
	logic            done_q;
	logic [15:0]     payload_q;
	logic [1:0]      status_q;

	logic            we, re;
	logic [W-1:0]    waddr_b, raddr_b;
	logic [31:0]     wdata, rdata;
	logic [W-1:0]    rsz;
	logic            ral;

	// Size and allocated bit of the tag word just read.
	assign rsz = {rdata[W-1:3], 3'b000};
	assign ral = rdata[0];

	btffa_ram #(.DEPTH(NWORDS), .AW(IW)) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr_b[IW+1:2]),
		.wdata (wdata),
		.re    (re),
		.raddr (raddr_b[IW+1:2]),
		.rdata (rdata)
	);

	// Configuration port.
	assign pready = 1'b1;
	assign prdata = (paddr[2] == btffa_pkg::REG_GROW_CHUNK) ? {15'd0, chunk_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chunk_q <= 17'(btffa_pkg::CHUNK_RESET);
		end else if (psel && penable && pwrite && paddr[2] == btffa_pkg::REG_GROW_CHUNK) begin
			chunk_q <= pwdata[16:0];
		end
	end

	// Request decode and derived sizes.
	logic [W-1:0] need_in, amount, gsize, split_rem, nb, ns;
	logic         gfail, split;

	always_comb begin
		if (request_bytes <= 16'd8) begin
			need_in = MINB_W;
		end else begin
			need_in = W'({(W'(request_bytes) + W'(15)) >> 3, 3'b000});
		end
		amount    = (need_q > W'(chunk_q)) ? need_q : W'(chunk_q);
		gsize     = {amount[W-1:2], 2'b00} + (amount[2] ? W'(4) : W'(0));
		gfail     = (brk_q > HEAP_W) || (gsize > HEAP_W - brk_q);
		split_rem = csz_q - need_q;
		split     = split_rem >= MINB_W;
		nb        = prev_al_q ? mbp_q : mbp_q - prev_q;
		ns        = msz_q + (prev_al_q ? W'(0) : prev_q) + (ral ? W'(0) : rsz);
	end

	// Memory requests for each step of the sequencer.
	always_comb begin
		we      = 1'b0;
		waddr_b = '0;
		wdata   = '0;
		re      = 1'b0;
		raddr_b = '0;
		case (state_q)
			S_INIT: begin
				we = 1'b1;
				case (ini_q)
					3'd0: begin waddr_b = W'(0); wdata = 32'd0; end
					3'd1: begin waddr_b = W'(4); wdata = 32'd8 | btffa_pkg::ALLOC_BIT; end
					3'd2: begin waddr_b = W'(8); wdata = 32'd8 | btffa_pkg::ALLOC_BIT; end
					3'd3: begin
						waddr_b = W'(12);
						wdata   = FIT ? 32'(btffa_pkg::FIRST_CHUNK) : btffa_pkg::ALLOC_BIT;
					end
					3'd4: begin waddr_b = CH_W + W'(8); wdata = 32'(btffa_pkg::FIRST_CHUNK); end
					default: begin waddr_b = CH_W + W'(12); wdata = btffa_pkg::ALLOC_BIT; end
				endcase
			end
			S_FF_RD, S_L_RD: begin
				re      = 1'b1;
				raddr_b = bp_q - W'(4);
			end
			S_GW0: begin
				we = 1'b1; waddr_b = bp_q - W'(4); wdata = 32'(msz_q);
			end
			S_GW1: begin
				we = 1'b1; waddr_b = bp_q + msz_q - W'(8); wdata = 32'(msz_q);
			end
			S_GW2: begin
				we = 1'b1; waddr_b = bp_q + msz_q - W'(4); wdata = btffa_pkg::ALLOC_BIT;
			end
			S_M_H: begin
				re = 1'b1; raddr_b = mbp_q - W'(4);
			end
			S_M_P: begin
				re = 1'b1; raddr_b = mbp_q - W'(8);
			end
			S_M_N: begin
				re = 1'b1; raddr_b = mbp_q + msz_q - W'(4);
			end
			S_MW0: begin
				we = 1'b1; waddr_b = mbp_q - W'(4); wdata = 32'(msz_q);
			end
			S_MW1: begin
				we = 1'b1; waddr_b = mbp_q + msz_q - W'(8); wdata = 32'(msz_q);
			end
			S_C0: begin
				we      = 1'b1;
				waddr_b = bp_q - W'(4);
				wdata   = 32'(split ? need_q : csz_q) | btffa_pkg::ALLOC_BIT;
			end
			S_C1: begin
				we      = 1'b1;
				waddr_b = bp_q + (split ? need_q : csz_q) - W'(8);
				wdata   = 32'(split ? need_q : csz_q) | btffa_pkg::ALLOC_BIT;
			end
			S_C2: begin
				we = 1'b1; waddr_b = bp_q + need_q - W'(4); wdata = 32'(split_rem);
			end
			S_C3: begin
				we = 1'b1; waddr_b = bp_q + csz_q - W'(8); wdata = 32'(split_rem);
			end
			S_F0: begin
				we = 1'b1; waddr_b = tgt_q - W'(4); wdata = 32'(csz_q);
			end
			S_F1: begin
				we = 1'b1; waddr_b = tgt_q + csz_q - W'(8); wdata = 32'(csz_q);
			end
			default: begin
			end
		endcase
	end

	// Sequencer: search, growth, merging and splitting.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_INIT;
			ini_q     <= '0;
			brk_q     <= FIT ? W'(16) + CH_W : W'(16);
			done_q    <= 1'b0;
			payload_q <= '0;
			status_q  <= btffa_pkg::ST_DONE;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_INIT: begin
					ini_q <= ini_q + 3'd1;
					if (ini_q == INI_LAST) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (start) begin
						op_q   <= op;
						need_q <= need_in;
						tgt_q  <= W'(block_offset);
						bp_q   <= W'(8);
						if (op == btffa_pkg::OP_FREE) begin
							state_q <= S_L_RD;
						end else if (request_bytes == 16'd0) begin
							done_q    <= 1'b1;
							payload_q <= '0;
							status_q  <= btffa_pkg::ST_NULL;
						end else begin
							state_q <= S_FF_RD;
						end
					end
				end
				S_FF_RD: begin
					state_q <= (bp_q < brk_q) ? S_FF_CHK : S_GROW;
				end
				S_FF_CHK: begin
					if (rsz == '0) begin
						state_q <= S_GROW;
					end else if (!ral && need_q <= rsz) begin
						csz_q   <= rsz;
						state_q <= S_C0;
					end else begin
						bp_q    <= bp_q + rsz;
						state_q <= S_FF_RD;
					end
				end
				S_GROW: begin
					if (gfail) begin
						done_q    <= 1'b1;
						payload_q <= '0;
						status_q  <= btffa_pkg::ST_OOM;
						state_q   <= S_IDLE;
					end else begin
						bp_q    <= brk_q;
						msz_q   <= gsize;
						brk_q   <= brk_q + gsize;
						state_q <= S_GW0;
					end
				end
				S_GW0: state_q <= S_GW1;
				S_GW1: state_q <= S_GW2;
				S_GW2: begin
					mbp_q   <= bp_q;
					state_q <= S_M_H;
				end
				S_M_H: state_q <= S_M_P;
				S_M_P: begin
					msz_q   <= rsz;
					state_q <= S_M_N;
				end
				S_M_N: begin
					prev_q    <= rsz;
					prev_al_q <= ral;
					state_q   <= S_M_C;
				end
				S_M_C: begin
					mbp_q <= nb;
					msz_q <= ns;
					if (prev_al_q && ral) begin
						bp_q    <= nb;
						csz_q   <= ns;
						state_q <= (op_q == btffa_pkg::OP_ALLOC) ? S_C0 : S_IDLE;
						if (op_q == btffa_pkg::OP_FREE) begin
							done_q    <= 1'b1;
							payload_q <= '0;
							status_q  <= btffa_pkg::ST_DONE;
						end
					end else begin
						state_q <= S_MW0;
					end
				end
				S_MW0: state_q <= S_MW1;
				S_MW1: begin
					bp_q  <= mbp_q;
					csz_q <= msz_q;
					if (op_q == btffa_pkg::OP_ALLOC) begin
						state_q <= S_C0;
					end else begin
						done_q    <= 1'b1;
						payload_q <= '0;
						status_q  <= btffa_pkg::ST_DONE;
						state_q   <= S_IDLE;
					end
				end
				S_C0: state_q <= S_C1;
				S_C1: begin
					if (split) begin
						state_q <= S_C2;
					end else begin
						done_q    <= 1'b1;
						payload_q <= bp_q[15:0];
						status_q  <= btffa_pkg::ST_DONE;
						state_q   <= S_IDLE;
					end
				end
				S_C2: state_q <= S_C3;
				S_C3: begin
					done_q    <= 1'b1;
					payload_q <= bp_q[15:0];
					status_q  <= btffa_pkg::ST_DONE;
					state_q   <= S_IDLE;
				end
				S_L_RD: begin
					if (bp_q < brk_q) begin
						state_q <= S_L_CHK;
					end else begin
						done_q    <= 1'b1;
						payload_q <= '0;
						status_q  <= btffa_pkg::ST_DONE;
						state_q   <= S_IDLE;
					end
				end
				S_L_CHK: begin
					if (rsz != '0 && bp_q == tgt_q && bp_q != W'(8) && ral) begin
						csz_q   <= rsz;
						state_q <= S_F0;
					end else if (rsz == '0 || bp_q >= tgt_q) begin
						done_q    <= 1'b1;
						payload_q <= '0;
						status_q  <= btffa_pkg::ST_DONE;
						state_q   <= S_IDLE;
					end else begin
						bp_q    <= bp_q + rsz;
						state_q <= S_L_RD;
					end
				end
				S_F0: state_q <= S_F1;
				S_F1: begin
					mbp_q   <= tgt_q;
					state_q <= S_M_H;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy           = (state_q != S_IDLE);
	assign done           = done_q;
	assign payload_offset = payload_q;
	assign status         = status_q;

`ifndef ASSERT_OFF
	// A result only follows work that was under way.
	a_done_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !$past(state_q == S_IDLE) || $past(start))
		else $error("result without a request");

	// Failed or null results never hand out a block.
	a_fail_null: assert property (@(posedge clk) disable iff (!arst_n)
		done && status != btffa_pkg::ST_DONE |-> payload_offset == 16'd0)
		else $error("block handed out with a failure status");

	// When the first chunk fits, the heap break never passes the end of the heap.
	a_break_bound: assert property (@(posedge clk) disable iff (!arst_n)
		brk_q <= HEAP_W || !FIT)
		else $error("heap break beyond heap");
`endif

endmodule
`default_nettype wire

/* src/btffa_ram.sv */
`default_nettype none
module btffa_ram #(
	parameter int DEPTH = 16384,
	parameter int AW    = 14
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [31:0]   wdata,
	input  wire logic          re,
	input  wire logic [AW-1:0] raddr,
	output logic      [31:0]   rdata
);

	logic [31:0] mem [DEPTH];

	// Single write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire
